// ===== design/ata_pio_read_queue_sequencer_unit_macros.svh =====
// assertion macros for the ata pio read queue sequencer
// used by the top level only; no other dependencies
`ifndef ATA_PIO_READ_QUEUE_SEQUENCER_UNIT_MACROS_SVH
`define ATA_PIO_READ_QUEUE_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define APRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aprq assertion failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define APRQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aprq assertion failed");

`endif

// ===== design/aprq_pkg.sv =====
// shared types and constants of the ata pio read queue sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package aprq_pkg;

    localparam int LBA_W   = 48;
    localparam int TAG_W   = 8;
    localparam int ADDR_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int ACT_W   = 3;
    localparam int OFS_W   = 3;
    localparam int STEP_W  = 4;

    localparam int QUEUE_DEPTH_DEF = 8;

    // ten task-file writes per issue, steps 0..9
    localparam logic [STEP_W-1:0] ISSUE_LAST = 4'd9;

    localparam logic [ACT_W-1:0] ACT_WRITE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_READ     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DONE     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NODATA   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SPURIOUS = 3'd4;
    localparam logic [ACT_W-1:0] ACT_BUSY     = 3'd5;
    localparam logic [ACT_W-1:0] ACT_FULL     = 3'd6;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_IRQ     = 1'b1;

    localparam logic [ADDR_W-1:0] IO_BASE_RST  = 16'h01F0;
    localparam logic [BYTE_W-1:0] CMD_READ_EXT = 8'h24;
    localparam logic [BYTE_W-1:0] DEVSEL_LBA   = 8'h40;

    localparam int STATUS_DRQ_BIT  = 3;
    localparam int STATUS_BUSY_BIT = 7;

    // register index taken from paddr[2]
    localparam logic REG_IO_BASE   = 1'b0;
    localparam logic REG_DRIVE_SEL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FULL,
        S_SPUR,
        S_FETCH_IRQ,
        S_READ,
        S_DONE,
        S_NODATA,
        S_FETCH_ISSUE,
        S_ISSUE,
        S_BUSY
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic multi;
    } t_q_stat;

    typedef struct packed {
        logic              data_port;
        logic [STEP_W-1:0] step;
    } t_unit_req;

    typedef struct packed {
        logic              strobe;
        logic [ACT_W-1:0]  action;
        logic [ADDR_W-1:0] port_address;
        logic [BYTE_W-1:0] port_value;
        logic [TAG_W-1:0]  done_tag;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ===== design/aprq_queue.sv =====
// request fifo: lba and tag memory with head/tail pointers and fill count
// depends on aprq_pkg
`default_nettype none

module aprq_queue import aprq_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_q_cmd            i_cmd,
    input  wire logic [LBA_W-1:0]  i_wr_lba,
    input  wire logic [TAG_W-1:0]  i_wr_tag,
    output t_q_stat                o_stat,
    output logic [LBA_W-1:0]       o_rd_lba,
    output logic [TAG_W-1:0]       o_rd_tag
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = LBA_W + TAG_W;

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] r_rd;

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    // registered read of the head entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_tail] <= {i_wr_lba, i_wr_tag};
        end
        r_rd <= mem[r_head];
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_cmd.push) begin
            n_tail  = ptr_inc(r_tail);
            n_count = r_count + CNT_W'(1);
        end
        if (i_cmd.pop) begin
            n_head  = ptr_inc(r_head);
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.multi = (r_count > CNT_W'(1));
    assign o_rd_lba     = r_rd[ENT_W-1:TAG_W];
    assign o_rd_tag     = r_rd[TAG_W-1:0];

endmodule

`default_nettype wire

// ===== design/aprq_bus_unit.sv =====
// shared bus unit: task-file step table and the io address adder
// depends on aprq_pkg
`default_nettype none

module aprq_bus_unit import aprq_pkg::*; (
    input  wire logic [ADDR_W-1:0] i_io_base,
    input  wire logic              i_drive_select,
    input  wire t_unit_req         i_req,
    input  wire logic [LBA_W-1:0]  i_lba,
    output logic [ADDR_W-1:0]      o_port_address,
    output logic [BYTE_W-1:0]      o_port_value
);

    logic [OFS_W-1:0]  ofs;
    logic [BYTE_W-1:0] val;

    always_comb begin
        case (i_req.step)
            4'd0: begin ofs = 3'd6; val = DEVSEL_LBA | {3'b000, i_drive_select, 4'b0000}; end
            4'd1: begin ofs = 3'd2; val = 8'h00; end
            4'd2: begin ofs = 3'd3; val = i_lba[31:24]; end
            4'd3: begin ofs = 3'd4; val = i_lba[39:32]; end
            4'd4: begin ofs = 3'd5; val = i_lba[47:40]; end
            4'd5: begin ofs = 3'd2; val = 8'h01; end
            4'd6: begin ofs = 3'd3; val = i_lba[7:0]; end
            4'd7: begin ofs = 3'd4; val = i_lba[15:8]; end
            4'd8: begin ofs = 3'd5; val = i_lba[23:16]; end
            4'd9: begin ofs = 3'd7; val = CMD_READ_EXT; end
            default: begin ofs = 3'd0; val = 8'h00; end
        endcase
        // data register sits at the base address itself
        if (i_req.data_port) begin
            ofs = '0;
            val = '0;
        end
    end

    assign o_port_address = i_io_base + ADDR_W'(ofs);
    assign o_port_value   = val;

endmodule

`default_nettype wire

// ===== design/aprq_ctrl.sv =====
// sequencer: walks one transaction through its results, one per cycle apart from the head-entry fetch states
// depends on aprq_pkg
`default_nettype none

module aprq_ctrl import aprq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic              i_opcode,
    input  wire logic [TAG_W-1:0]  i_tag,
    input  wire logic              i_drq,
    input  wire logic              i_busy_flag,
    input  wire t_q_stat           i_stat,
    input  wire logic [TAG_W-1:0]  i_rd_tag,
    input  wire logic [ADDR_W-1:0] i_unit_addr,
    input  wire logic [BYTE_W-1:0] i_unit_value,
    output logic                   o_busy,
    output t_q_cmd                 o_q_cmd,
    output t_unit_req              o_unit_req,
    output t_result                o_result
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_drq;
    logic              r_bsy;
    logic [TAG_W-1:0]  r_tag;

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    if (i_opcode == OP_ENQUEUE) begin
                        if (i_stat.full) begin
                            n_state = S_FULL;
                        end else if (i_stat.empty) begin
                            n_state = S_FETCH_ISSUE;
                        end
                    end else if (i_stat.empty) begin
                        n_state = S_SPUR;
                    end else begin
                        n_state = S_FETCH_IRQ;
                    end
                end
            end
            S_FULL:      n_state = S_IDLE;
            S_SPUR:      n_state = r_bsy ? S_BUSY : S_IDLE;
            S_FETCH_IRQ: n_state = r_drq ? S_READ : S_NODATA;
            S_READ:      n_state = S_DONE;
            S_DONE: begin
                if (i_stat.multi) begin
                    n_state = S_FETCH_ISSUE;
                end else begin
                    n_state = r_bsy ? S_BUSY : S_IDLE;
                end
            end
            S_NODATA: begin
                n_state = S_ISSUE;
                n_step  = '0;
            end
            S_FETCH_ISSUE: begin
                n_state = S_ISSUE;
                n_step  = '0;
            end
            S_ISSUE: begin
                if (r_step == ISSUE_LAST) begin
                    n_state = r_bsy ? S_BUSY : S_IDLE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_BUSY:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy               = (r_state != S_IDLE);
        o_q_cmd.push         = (r_state == S_IDLE) && i_accept
                               && (i_opcode == OP_ENQUEUE) && !i_stat.full;
        o_q_cmd.pop          = (r_state == S_DONE);
        o_unit_req.data_port = (r_state == S_READ);
        o_unit_req.step      = r_step;
        o_result             = '0;
        case (r_state)
            S_FULL: begin
                o_result.strobe   = 1'b1;
                o_result.action   = ACT_FULL;
                o_result.done_tag = r_tag;
                o_result.last     = 1'b1;
            end
            S_SPUR: begin
                o_result.strobe = 1'b1;
                o_result.action = ACT_SPURIOUS;
                o_result.last   = !r_bsy;
            end
            S_READ: begin
                o_result.strobe       = 1'b1;
                o_result.action       = ACT_READ;
                o_result.port_address = i_unit_addr;
                o_result.done_tag     = i_rd_tag;
            end
            S_DONE: begin
                o_result.strobe   = 1'b1;
                o_result.action   = ACT_DONE;
                o_result.done_tag = i_rd_tag;
                o_result.last     = !i_stat.multi && !r_bsy;
            end
            S_NODATA: begin
                o_result.strobe   = 1'b1;
                o_result.action   = ACT_NODATA;
                o_result.done_tag = i_rd_tag;
            end
            S_ISSUE: begin
                o_result.strobe       = 1'b1;
                o_result.action       = ACT_WRITE;
                o_result.port_address = i_unit_addr;
                o_result.port_value   = i_unit_value;
                o_result.done_tag     = i_rd_tag;
                o_result.last         = (r_step == ISSUE_LAST) && !r_bsy;
            end
            S_BUSY: begin
                o_result.strobe = 1'b1;
                o_result.action = ACT_BUSY;
                o_result.last   = 1'b1;
            end
            default: o_result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // per-transaction flags; busy check only applies to interrupts
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_accept) begin
            r_drq <= i_drq;
            r_bsy <= (i_opcode == OP_IRQ) && i_busy_flag;
            r_tag <= i_tag;
        end
    end

endmodule

`default_nettype wire

// ===== design/ata_pio_read_queue_sequencer_unit.sv =====
// top level of the ata pio lba48 read queue sequencer
// depends on aprq_pkg, aprq_queue, aprq_bus_unit, aprq_ctrl and the macros header
`default_nettype none

// how to use it
// - command channel: drive the fields and raise start; the transaction is taken at
//   a rising edge where start is high and busy is low. opcode 0 queues a read
//   request (lba, tag), opcode 1 reports a drive interrupt with its two status bytes
// - result channel: each result is shown for exactly one cycle with o_strobe high;
//   o_last marks the final result of a transaction. the receiver cannot stall it
// - apb port: io_base at byte address 0, drive_select at 4; pready is tied high
//   and writes are expected only while busy is low and the last result is out
// - order: a full queue or a spurious interrupt gives its first result from the state
//   register through the result output register; otherwise a head-entry fetch comes first
// - busy stays high while each result is formed and through each head-entry memory read,
//   is already low while the final result is shown, and no new transaction is taken until it falls
// - an enqueue into a non-empty queue that is not full gives no result and busy does not rise
// - one shared adder forms every port address; the sequencer steps it once a
//   cycle through the ten task-file writes
// - reset (synchronous, active low) empties the queue, restores io_base to 0x1f0
//   and master drive select, and drops any transaction in flight

module ata_pio_read_queue_sequencer_unit import aprq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command channel
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_opcode,
    input  wire logic [LBA_W-1:0]  i_request_lba,
    input  wire logic [TAG_W-1:0]  i_request_tag,
    input  wire logic [7:0]        i_status_at_irq,
    input  wire logic [7:0]        i_status_after,
    // result channel
    output logic                   o_strobe,
    output logic [ACT_W-1:0]       o_action,
    output logic [ADDR_W-1:0]      o_port_address,
    output logic [BYTE_W-1:0]      o_port_value,
    output logic [TAG_W-1:0]       o_done_tag,
    output logic                   o_last,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

`include "ata_pio_read_queue_sequencer_unit_macros.svh"

    // configuration registers
    logic [ADDR_W-1:0] r_io_base;
    logic              r_drive_select;
    logic              cfg_wr;

    // internal hookups
    logic              accept;
    t_q_cmd            q_cmd;
    t_q_stat           q_stat;
    logic [LBA_W-1:0]  rd_lba;
    logic [TAG_W-1:0]  rd_tag;
    t_unit_req         unit_req;
    logic [ADDR_W-1:0] unit_addr;
    logic [BYTE_W-1:0] unit_value;
    t_result           result;

    // result output register
    logic              r_strobe;
    t_result           r_result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_io_base      <= IO_BASE_RST;
            r_drive_select <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_IO_BASE:   r_io_base      <= pwdata[ADDR_W-1:0];
                REG_DRIVE_SEL: r_drive_select <= pwdata[0];
                default:       r_io_base      <= r_io_base;
            endcase
        end
    end

    // readback, byte lane offset bits ignored
    always_comb begin
        case (paddr[2])
            REG_IO_BASE:   prdata = {{(32 - ADDR_W){1'b0}}, r_io_base};
            REG_DRIVE_SEL: prdata = {31'b0, r_drive_select};
            default:       prdata = '0;
        endcase
    end

    assign accept = start && !busy;

    aprq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (q_cmd),
        .i_wr_lba (i_request_lba),
        .i_wr_tag (i_request_tag),
        .o_stat   (q_stat),
        .o_rd_lba (rd_lba),
        .o_rd_tag (rd_tag)
    );

    // one adder shared by the data read and every task-file write
    aprq_bus_unit u_bus_unit (
        .i_io_base      (r_io_base),
        .i_drive_select (r_drive_select),
        .i_req          (unit_req),
        .i_lba          (rd_lba),
        .o_port_address (unit_addr),
        .o_port_value   (unit_value)
    );

    aprq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_opcode     (i_opcode),
        .i_tag        (i_request_tag),
        .i_drq        (i_status_at_irq[STATUS_DRQ_BIT]),
        .i_busy_flag  (i_status_after[STATUS_BUSY_BIT]),
        .i_stat       (q_stat),
        .i_rd_tag     (rd_tag),
        .i_unit_addr  (unit_addr),
        .i_unit_value (unit_value),
        .o_busy       (busy),
        .o_q_cmd      (q_cmd),
        .o_unit_req   (unit_req),
        .o_result     (result)
    );

    // strobe is control and gets reset; the payload just follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= result.strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= result;
    end

    assign o_strobe       = r_strobe;
    assign o_action       = r_result.action;
    assign o_port_address = r_result.port_address;
    assign o_port_value   = r_result.port_value;
    assign o_done_tag     = r_result.done_tag;
    assign o_last         = r_result.last;

    // a result only follows a cycle of work
    `APRQ_ASSERT_IMP(a_strobe_after_busy, i_clk, i_rst_n, o_strobe, $past(busy))
    // a final result is never directly followed by another
    `APRQ_ASSERT_NXT(a_gap_after_last, i_clk, i_rst_n, o_strobe && o_last, !o_strobe)
    // the queue never pushes and pops in one cycle, and never pushes while full
    `APRQ_ASSERT_IMP(a_no_push_pop, i_clk, i_rst_n, q_cmd.push, !q_cmd.pop && !q_stat.full)

endmodule

`default_nettype wire

// ===== tb/tb_ata_pio_read_queue_sequencer_unit.sv =====
// self-checking testbench for the ata pio lba48 read queue sequencer
// depends on aprq_pkg and the top level ata_pio_read_queue_sequencer_unit
// directed and random command traffic, apb setup, in-order result checking
`timescale 1ns / 1ps

module tb_ata_pio_read_queue_sequencer_unit;
    import aprq_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int Q_DEPTH     = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    // idle slack after the last owed result has come out
    localparam int SETTLE      = 16;

    // task-file register offsets from io_base
    localparam logic [2:0] OFS_SECCOUNT = 3'd2;
    localparam logic [2:0] OFS_LBA_LO   = 3'd3;
    localparam logic [2:0] OFS_LBA_MID  = 3'd4;
    localparam logic [2:0] OFS_LBA_HI   = 3'd5;
    localparam logic [2:0] OFS_DEVICE   = 3'd6;
    localparam logic [2:0] OFS_COMMAND  = 3'd7;

    // apb byte addresses of the two registers
    localparam logic [2:0] ADDR_IO_BASE   = 3'd0;
    localparam logic [2:0] ADDR_DRIVE_SEL = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] value;
        logic [TAG_W-1:0]  tag;
        logic              last;
    } t_bus_op;

    // clock, reset and every block input start at known values
    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              start           = 1'b0;
    logic              i_opcode        = OP_ENQUEUE;
    logic [LBA_W-1:0]  i_request_lba   = '0;
    logic [TAG_W-1:0]  i_request_tag   = '0;
    logic [7:0]        i_status_at_irq = '0;
    logic [7:0]        i_status_after  = '0;
    logic              psel            = 1'b0;
    logic              penable         = 1'b0;
    logic              pwrite          = 1'b0;
    logic [2:0]        paddr           = '0;
    logic [31:0]       pwdata          = '0;

    logic              busy;
    logic              o_strobe;
    logic [ACT_W-1:0]  o_action;
    logic [ADDR_W-1:0] o_port_address;
    logic [BYTE_W-1:0] o_port_value;
    logic [TAG_W-1:0]  o_done_tag;
    logic              o_last;
    logic [31:0]       prdata;
    logic              pready;

    // bus activity still owed by the block, oldest first
    t_bus_op expected_bus_ops[$];

    // shadow of the request queue and the two registers
    logic [LBA_W-1:0]  shadow_lba [Q_DEPTH];
    logic [TAG_W-1:0]  shadow_tag [Q_DEPTH];
    int                q_head  = 0;
    int                q_tail  = 0;
    int                q_count = 0;
    logic [ADDR_W-1:0] cfg_io_base = IO_BASE_RST;
    logic              cfg_slave   = 1'b0;

    int  n_mismatch = 0;
    int  items_sent = 0;
    int  cycles     = 0;
    // when set the sender offers transactions back to back
    bit  steady     = 1'b0;

    ata_pio_read_queue_sequencer_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_request_lba   (i_request_lba),
        .i_request_tag   (i_request_tag),
        .i_status_at_irq (i_status_at_irq),
        .i_status_after  (i_status_after),
        .o_strobe        (o_strobe),
        .o_action        (o_action),
        .o_port_address  (o_port_address),
        .o_port_value    (o_port_value),
        .o_done_tag      (o_done_tag),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // hard stop if the block hangs or stops answering
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction of the bus activity
    // ------------------------------------------------------------------

    task automatic push_op(input logic [ACT_W-1:0] act, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] val, input logic [TAG_W-1:0] tag);
        t_bus_op op;
        op.action = act;
        op.addr   = addr;
        op.value  = val;
        op.tag    = tag;
        op.last   = 1'b0;
        expected_bus_ops.push_back(op);
    endtask

    task automatic push_port_write(input logic [2:0] ofs, input logic [BYTE_W-1:0] val,
                                   input logic [TAG_W-1:0] tag);
        logic [ADDR_W-1:0] a;
        // address wraps at 16 bits
        a = cfg_io_base + {13'd0, ofs};
        push_op(ACT_WRITE, a, val, tag);
    endtask

    // lba48 task-file sequence for the head request: high bytes first, then low
    task automatic predict_issue_head();
        logic [LBA_W-1:0] lba;
        logic [TAG_W-1:0] tag;
        lba = shadow_lba[q_head];
        tag = shadow_tag[q_head];
        push_port_write(OFS_DEVICE, DEVSEL_LBA | {3'b000, cfg_slave, 4'b0000}, tag);
        push_port_write(OFS_SECCOUNT, 8'd0, tag);
        push_port_write(OFS_LBA_LO, lba[31:24], tag);
        push_port_write(OFS_LBA_MID, lba[39:32], tag);
        push_port_write(OFS_LBA_HI, lba[47:40], tag);
        push_port_write(OFS_SECCOUNT, 8'd1, tag);
        push_port_write(OFS_LBA_LO, lba[7:0], tag);
        push_port_write(OFS_LBA_MID, lba[15:8], tag);
        push_port_write(OFS_LBA_HI, lba[23:16], tag);
        push_port_write(OFS_COMMAND, CMD_READ_EXT, tag);
    endtask

    task automatic predict_bus_activity(input logic op, input logic [LBA_W-1:0] lba,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [7:0] st_irq, input logic [7:0] st_after);
        int               n_before;
        logic [TAG_W-1:0] head_tag;
        n_before = expected_bus_ops.size();
        if (op == OP_ENQUEUE) begin
            if (q_count >= Q_DEPTH) begin
                // dropped, queue untouched
                push_op(ACT_FULL, '0, '0, tag);
            end else begin
                shadow_lba[q_tail] = lba;
                shadow_tag[q_tail] = tag;
                q_tail  = (q_tail + 1) % Q_DEPTH;
                q_count = q_count + 1;
                // only a request landing in an empty queue goes straight to the drive
                if (q_count == 1)
                    predict_issue_head();
            end
        end else begin
            if (q_count == 0) begin
                push_op(ACT_SPURIOUS, '0, '0, '0);
            end else begin
                head_tag = shadow_tag[q_head];
                if (st_irq[STATUS_DRQ_BIT]) begin
                    push_op(ACT_READ, cfg_io_base, '0, head_tag);
                    push_op(ACT_DONE, '0, '0, head_tag);
                    q_head  = (q_head + 1) % Q_DEPTH;
                    q_count = q_count - 1;
                end else begin
                    // no drq: head stays and gets reissued below
                    push_op(ACT_NODATA, '0, '0, head_tag);
                end
                if (q_count > 0)
                    predict_issue_head();
            end
            if (st_after[STATUS_BUSY_BIT])
                push_op(ACT_BUSY, '0, '0, '0);
        end
        if (expected_bus_ops.size() > n_before)
            expected_bus_ops[expected_bus_ops.size() - 1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // result checking, one expected result per strobe
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_bus_op want;
        if (i_rst_n && o_strobe) begin
            if (expected_bus_ops.size() == 0) begin
                $error("unexpected result: action %0d tag %0d", o_action, o_done_tag);
                n_mismatch = n_mismatch + 1;
            end else begin
                want = expected_bus_ops.pop_front();
                if (o_action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, o_action);
                    n_mismatch = n_mismatch + 1;
                end
                if (o_port_address !== want.addr) begin
                    $error("port_address: expected %h, got %h", want.addr, o_port_address);
                    n_mismatch = n_mismatch + 1;
                end
                if (o_port_value !== want.value) begin
                    $error("port_value: expected %h, got %h", want.value, o_port_value);
                    n_mismatch = n_mismatch + 1;
                end
                if (o_done_tag !== want.tag) begin
                    $error("done_tag: expected %h, got %h", want.tag, o_done_tag);
                    n_mismatch = n_mismatch + 1;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    n_mismatch = n_mismatch + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [LBA_W-1:0] rand_lba();
        logic [LBA_W-1:0] v;
        v[31:0]  = $urandom();
        v[47:32] = 16'($urandom_range(0, 16'hFFFF));
        return v;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_cycles();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 50);
    endfunction

    // offer one transaction, wait for the accepting edge, then maybe idle
    task automatic send_item(input logic op, input logic [LBA_W-1:0] lba,
                             input logic [TAG_W-1:0] tag,
                             input logic [7:0] st_irq, input logic [7:0] st_after);
        int gap;
        i_opcode        <= op;
        i_request_lba   <= lba;
        i_request_tag   <= tag;
        i_status_at_irq <= st_irq;
        i_status_after  <= st_after;
        start           <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_bus_activity(op, lba, tag, st_irq, st_after);
        items_sent = items_sent + 1;
        gap = idle_cycles();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_enqueue(input logic [LBA_W-1:0] lba, input logic [TAG_W-1:0] tag);
        send_item(OP_ENQUEUE, lba, tag, rand_byte(), rand_byte());
    endtask

    task automatic send_irq(input logic [7:0] st_irq, input logic [7:0] st_after);
        send_item(OP_IRQ, rand_lba(), rand_byte(), st_irq, st_after);
    endtask

    // interrupt with drq most of the time and the busy flag now and then
    task automatic send_random_irq();
        logic [7:0] sa;
        logic [7:0] sb;
        sa = rand_byte();
        sb = rand_byte();
        sa[STATUS_DRQ_BIT]  = ($urandom_range(0, 99) < 85);
        sb[STATUS_BUSY_BIT] = ($urandom_range(0, 99) < 15);
        send_irq(sa, sb);
    endtask

    // stop offering and let every owed result come out, plus some slack
    task automatic wait_quiet();
        start <= 1'b0;
        while (expected_bus_ops.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // apb write, setup then access; upper data bits carry junk
    task automatic cfg_write(input logic [2:0] addr, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        if (addr == ADDR_IO_BASE)
            pwdata <= {16'($urandom()), value};
        else
            pwdata <= {31'($urandom()), value[0]};
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_IO_BASE)
            cfg_io_base = value;
        else
            cfg_slave = value[0];
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every action but the full report, with the reset register values and extreme field values
    task automatic test_all_actions_default_cfg();
        send_enqueue({LBA_W{1'b1}}, 8'hFF);     // issue at once
        send_enqueue('0, 8'h00);                // queued behind it
        send_irq(8'hF7, 8'h7F);                 // no drq, head reissued
        send_irq(8'h08, 8'h80);                 // read, done, next issue, busy
        send_irq(8'hFF, 8'hFF);                 // last entry served, busy
        send_irq(8'h00, 8'h00);                 // spurious
        send_irq(8'h00, 8'hFF);                 // spurious then busy
    endtask

    // slave drive, io_base at the top so the offsets wrap, queue overflow
    task automatic test_overflow_slave_wrap();
        int i;
        cfg_write(ADDR_IO_BASE, 16'hFFFF);
        cfg_write(ADDR_DRIVE_SEL, 16'd1);
        send_enqueue(48'h8000_0000_0001, 8'h01);
        for (i = 1; i < Q_DEPTH; i++)
            send_enqueue(rand_lba(), rand_byte());
        send_enqueue(rand_lba(), 8'hA5);        // dropped, queue full
        while (q_count > 0)
            send_irq(8'h08, 8'h00);
    endtask

    // bursts of well-formed request/interrupt sequences with some noise mixed in
    task automatic test_random_traffic(input int n_items);
        int first;
        int k;
        int i;
        int guard;
        first = items_sent;
        while (items_sent - first < n_items) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                k = $urandom_range(1, 5);
                for (i = 0; i < k; i++)
                    send_item(1'($urandom_range(0, 1)), rand_lba(), rand_byte(),
                              rand_byte(), rand_byte());
            end else begin
                k = $urandom_range(1, Q_DEPTH);
                if ($urandom_range(0, 7) == 0)
                    k = $urandom_range(Q_DEPTH + 1, Q_DEPTH + 3);
                for (i = 0; i < k; i++)
                    send_enqueue(rand_lba(), rand_byte());
                // hold off until the drive side has caught up
                if ($urandom_range(0, 7) == 0)
                    wait_quiet();
                guard = 0;
                while (q_count > 0 && guard < 40) begin
                    send_random_irq();
                    guard++;
                end
                if ($urandom_range(0, 5) == 0)
                    send_random_irq();
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_all_actions_default_cfg();
        wait_quiet();
        test_overflow_slave_wrap();
        wait_quiet();

        cfg_write(ADDR_IO_BASE, 16'h0000);
        cfg_write(ADDR_DRIVE_SEL, 16'd0);
        test_random_traffic(84);
        wait_quiet();

        cfg_write(ADDR_IO_BASE, 16'($urandom()));
        cfg_write(ADDR_DRIVE_SEL, 16'd1);
        test_random_traffic(84);
        wait_quiet();

        cfg_write(ADDR_IO_BASE, 16'hFFF9);
        cfg_write(ADDR_DRIVE_SEL, 16'd0);
        test_random_traffic(84);
        wait_quiet();

        cfg_write(ADDR_IO_BASE, IO_BASE_RST);
        cfg_write(ADDR_DRIVE_SEL, 16'd1);
        test_random_traffic(84);
        wait_quiet();

        if (n_mismatch == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
